// ----- src/xps_pkg.sv -----
// Shared types, constants and the prefix classifier for the x86 prefix scanner.
// No dependencies.
package xps_pkg;

    localparam int MAX_PREFIXES = 15;
    localparam int DEPTH = (MAX_PREFIXES < 1) ? 1 : ((MAX_PREFIXES > 15) ? 15 : MAX_PREFIXES);
    localparam int CFG_AW = 3;

    localparam logic [1:0] MODE_64 = 2'd2;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [0:0] REG_CPU_MODE = 1'b0;

    localparam logic [2:0] GRP_LOCK_REP = 3'd0;
    localparam logic [2:0] GRP_SEGMENT = 3'd1;
    localparam logic [2:0] GRP_OPSIZE = 3'd2;
    localparam logic [2:0] GRP_ADSIZE = 3'd3;
    localparam logic [2:0] GRP_REX = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic       entry_valid;
        logic [7:0] prefix_byte;
        logic [2:0] prefix_group;
        logic       is_mandatory;
        logic [3:0] pfx_total;
        logic       overflow;
        logic [7:0] next_byte;
        logic       stream_ended;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       mand;
        logic [2:0] group;
        logic [7:0] pbyte;
    } t_entry;

    typedef struct packed {
        logic write;
        logic shift;
        logic clr_mand;
    } t_cell_ctl;

    typedef struct packed {
        logic       hit;
        logic       mand;
        logic [2:0] group;
    } t_class;

    function automatic t_class classify(input logic [7:0] b, input logic [1:0] mode);
        t_class c;
        c = '{hit: 1'b1, mand: 1'b0, group: GRP_LOCK_REP};
        unique case (b)
            8'hF0: c.group = GRP_LOCK_REP;
            8'hF2, 8'hF3: c.mand = 1'b1;
            8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65: c.group = GRP_SEGMENT;
            8'h66: begin
                c.group = GRP_OPSIZE;
                c.mand = 1'b1;
            end
            8'h67: c.group = GRP_ADSIZE;
            default: begin
                if (mode == MODE_64 && b[7:4] == 4'h4) begin
                    c.group = GRP_REX;
                end else begin
                    c.hit = 1'b0;
                end
            end
        endcase
        return c;
    endfunction

endpackage

// ----- src/xps_cell.sv -----
// One slot of the prefix store: loads a new prefix, takes its neighbor's entry
// on a shift, and drops its mandatory mark on request. Uses xps_pkg.
module xps_cell
    import xps_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_wr_entry,
    input  t_entry    i_nbr_entry,
    output t_entry    o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.write) begin
            n_entry = i_wr_entry;
        end else if (i_ctl.shift) begin
            n_entry = i_nbr_entry;
        end else if (i_ctl.clr_mand) begin
            n_entry.mand = 1'b0;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ----- src/x86_prefix_scanner.sv -----
// Top level of the x86 prefix scanner: control, APB register and the cell row.
// Uses xps_pkg and xps_cell.
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_stall | t_in_item  i_in_data
//  out     | output    | o_out_valid/i_out_stall | t_out_item o_out_data
//  cfg     | input     | APB psel/penable      | cpu_mode at byte 0
//
// A prefix byte is taken and yields no record.
// A terminating byte or end of stream starts a run of max(n,1) records, n the
// stored prefix count, one per cycle unless the output stalls, from the head cell as the row shifts.
// o_in_stall is high from that transaction until the last record is taken.
// Output stalls hold the head cell and the run registers in place.
// Synchronous reset clears count, overflow and run control; cpu_mode resets to 1.
module x86_prefix_scanner
    import xps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [1:0] r_mode;
    logic [3:0] r_count;
    logic       r_ovf;
    logic       r_emit;
    logic [3:0] r_rem;
    logic [3:0] r_run_n;
    logic       r_none;
    logic       r_run_ovf;
    logic [7:0] r_next;
    logic       r_eos;

    logic   in_acc;
    logic   out_acc;
    logic   full;
    logic   is_pfx;
    t_class cls;
    t_entry wr_entry;
    t_entry cells [DEPTH];
    t_entry head;

    assign pready = 1'b1;
    assign prdata = (paddr[CFG_AW-1] == REG_CPU_MODE) ? {30'd0, r_mode} : 32'd0;

    assign o_in_stall = r_emit;
    assign in_acc = i_in_valid && !r_emit;
    assign out_acc = r_emit && !i_out_stall;
    assign cls = classify(i_in_data.in_byte, r_mode);
    assign is_pfx = cls.hit && !i_in_data.end_of_stream;
    assign full = (r_count == 4'(DEPTH));
    assign wr_entry = '{mand: cls.mand, group: cls.group, pbyte: i_in_data.in_byte};

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_cell_ctl ctl;
            t_entry    nbr;
            assign ctl = '{
                write:    in_acc && is_pfx && (r_count == 4'(gi)),
                shift:    out_acc,
                clr_mand: in_acc && is_pfx && !cls.mand && (cls.group != GRP_REX)
            };
            if (gi == DEPTH - 1) begin : g_tail
                assign nbr = '0;
            end else begin : g_mid
                assign nbr = cells[gi+1];
            end
            xps_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_wr_entry (wr_entry),
                .i_nbr_entry(nbr),
                .o_entry    (cells[gi])
            );
        end
    endgenerate

    assign head = cells[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
            r_count <= '0;
            r_ovf <= 1'b0;
            r_emit <= 1'b0;
            r_rem <= '0;
        end else begin
            if (psel && penable && pwrite && paddr[CFG_AW-1] == REG_CPU_MODE) begin
                r_mode <= pwdata[1:0];
            end
            if (in_acc) begin
                if (is_pfx) begin
                    if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_count <= r_count + 4'd1;
                    end
                end else begin
                    r_emit <= 1'b1;
                    r_rem <= (r_count == 4'd0) ? 4'd1 : r_count;
                    r_run_n <= r_count;
                    r_none <= (r_count == 4'd0);
                    r_run_ovf <= r_ovf;
                    r_next <= i_in_data.end_of_stream ? 8'd0 : i_in_data.in_byte;
                    r_eos <= i_in_data.end_of_stream;
                    r_count <= '0;
                    r_ovf <= 1'b0;
                end
            end
            if (out_acc) begin
                r_rem <= r_rem - 4'd1;
                if (r_rem == 4'd1) begin
                    r_emit <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid = r_emit;

    always_comb begin
        o_out_data.entry_valid = !r_none;
        o_out_data.prefix_byte = r_none ? 8'd0 : head.pbyte;
        o_out_data.prefix_group = r_none ? 3'd0 : head.group;
        o_out_data.is_mandatory = r_none ? 1'b0 : head.mand;
        o_out_data.pfx_total = r_run_n;
        o_out_data.overflow = r_run_ovf;
        o_out_data.next_byte = r_next;
        o_out_data.stream_ended = r_eos;
        o_out_data.last = (r_rem == 4'd1);
    end

endmodule

// ----- sim/x86_prefix_scanner_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for x86_prefix_scanner: directed and random byte streams,
// APB mode writes, random idling and a long output hold-off, records checked against
// an in-bench predictor. Depends on xps_pkg and the scanner RTL.
module x86_prefix_scanner_tb;
    import xps_pkg::*;

    localparam logic [1:0] MODE_16 = 2'd0;
    localparam logic [1:0] MODE_32 = 2'd1;
    localparam logic [1:0] MODE_RSVD = 2'd3;
    localparam logic [CFG_AW-1:0] CPU_MODE_ADDR = CFG_AW'(4 * REG_CPU_MODE);
    localparam int IDLE_PCT = 36;
    localparam int DRAIN_CYCLES = 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // predictor state
    logic [7:0] pfx_byte [DEPTH];
    logic [2:0] pfx_grp [DEPTH];
    logic       pfx_mand [DEPTH];
    int         pfx_count = 0;
    logic       pfx_ovf = 1'b0;
    logic [1:0] mode_shadow = MODE_RESET;

    t_out_item record_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_records = 0;
    int n_runs = 0;
    bit no_idle = 1'b0;
    int hold_req = 0;
    int hold_left = 0;

    logic [7:0] legacy_pfx [11] = '{8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26,
                                    8'h64, 8'h65, 8'h66, 8'h67};

    x86_prefix_scanner dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("Timeout: scanner stopped making progress");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit prefix_class(input logic [7:0] b, input logic [1:0] mode,
                                        output logic [2:0] g, output logic m);
        m = 1'b0;
        g = GRP_LOCK_REP;
        case (b)
            8'hF0: return 1'b1;
            8'hF2, 8'hF3: begin
                m = 1'b1;
                return 1'b1;
            end
            8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65: begin
                g = GRP_SEGMENT;
                return 1'b1;
            end
            8'h66: begin
                g = GRP_OPSIZE;
                m = 1'b1;
                return 1'b1;
            end
            8'h67: begin
                g = GRP_ADSIZE;
                return 1'b1;
            end
            default: ;
        endcase
        if (mode == MODE_64 && b >= 8'h40 && b <= 8'h4F) begin
            g = GRP_REX;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic string fmt_rec(input t_out_item r);
        return $sformatf({"valid=%0b byte=%h grp=%0d mand=%0b cnt=%0d ovf=%0b",
                          " next=%h eos=%0b last=%0b"},
                         r.entry_valid, r.prefix_byte, r.prefix_group, r.is_mandatory,
                         r.pfx_total, r.overflow, r.next_byte, r.stream_ended, r.last);
    endfunction

    task automatic report_error(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    task automatic predict_records(input t_in_item it);
        t_out_item rec;
        logic [2:0] g;
        logic m;
        bit hit;
        int k;
        hit = 1'b0;
        if (!it.end_of_stream) begin
            hit = prefix_class(it.in_byte, mode_shadow, g, m);
        end
        if (hit) begin
            if (!m && g != GRP_REX) begin
                for (k = 0; k < pfx_count; k++) pfx_mand[k] = 1'b0;
            end
            if (pfx_count < DEPTH) begin
                pfx_byte[pfx_count] = it.in_byte;
                pfx_grp[pfx_count] = g;
                pfx_mand[pfx_count] = m;
                pfx_count++;
            end else begin
                pfx_ovf = 1'b1;
            end
        end else begin
            n_runs++;
            rec = '0;
            rec.overflow = pfx_ovf;
            rec.next_byte = it.end_of_stream ? 8'h00 : it.in_byte;
            rec.stream_ended = it.end_of_stream;
            if (pfx_count == 0) begin
                rec.last = 1'b1;
                record_q.push_back(rec);
            end else begin
                for (k = 0; k < pfx_count; k++) begin
                    rec.entry_valid = 1'b1;
                    rec.prefix_byte = pfx_byte[k];
                    rec.prefix_group = pfx_grp[k];
                    rec.is_mandatory = pfx_mand[k];
                    rec.pfx_total = 4'(pfx_count);
                    rec.last = (k == pfx_count - 1);
                    record_q.push_back(rec);
                end
            end
            pfx_count = 0;
            pfx_ovf = 1'b0;
        end
    endtask

    // monitor: predict on accepted input, then check accepted output
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_records(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                n_records++;
                if (record_q.size() == 0) begin
                    report_error({"unexpected record ", fmt_rec(o_out_data)});
                end else begin
                    want = record_q.pop_front();
                    if (o_out_data !== want) begin
                        report_error({"record mismatch\n  exp ", fmt_rec(want),
                                      "\n  got ", fmt_rec(o_out_data)});
                    end
                end
            end
        end
    end

    // output side: random stalls (none while no_idle is set), or a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else if (no_idle) begin
            i_out_stall = 1'b0;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eos);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = '{in_byte: b, end_of_stream: eos};
        n_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (record_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] mode);
        logic [31:0] wd;
        wait_drained();
        wd = $urandom;
        wd[1:0] = mode;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = CPU_MODE_ADDR;
        pwdata = wd;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        mode_shadow = mode;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[1:0] !== mode) begin
            report_error($sformatf("cpu_mode readback exp %0d got %0d", mode, prdata[1:0]));
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [7:0] random_prefix();
        if (mode_shadow == MODE_64 && $urandom_range(0, 3) == 0) begin
            return {4'h4, 4'($urandom)};
        end
        return legacy_pfx[$urandom_range(0, 10)];
    endfunction

    function automatic logic [7:0] random_terminator();
        logic [7:0] b;
        logic [2:0] g;
        logic m;
        do b = 8'($urandom); while (prefix_class(b, mode_shadow, g, m));
        return b;
    endfunction

    task automatic send_random_instr();
        int np;
        if ($urandom_range(0, 99) < 15) begin
            send_item(8'($urandom), $urandom_range(0, 7) == 0);
            return;
        end
        if ($urandom_range(0, 19) == 0) begin
            np = $urandom_range(DEPTH - 1, DEPTH + 2);
        end else begin
            np = $urandom_range(0, 4);
        end
        repeat (np) send_item(random_prefix(), 1'b0);
        if ($urandom_range(0, 9) == 0) begin
            send_item(8'($urandom), 1'b1);
        end else begin
            send_item(random_terminator(), 1'b0);
        end
    endtask

    task automatic test_no_prefix();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hA5, 1'b1);
        send_item(8'h48, 1'b0);
    endtask

    task automatic test_each_prefix();
        foreach (legacy_pfx[i]) send_item(legacy_pfx[i], 1'b0);
        send_item(8'h0F, 1'b0);
        send_item(8'h2E, 1'b0);
        send_item(8'hF2, 1'b0);
        send_item(8'h66, 1'b0);
        send_item(8'h5A, 1'b1);
    endtask

    task automatic test_rex();
        set_mode(MODE_64);
        send_item(8'hF3, 1'b0);
        send_item(8'h48, 1'b0);
        send_item(8'h4F, 1'b0);
        send_item(8'h40, 1'b0);
        send_item(8'hC3, 1'b0);
    endtask

    task automatic test_store_full();
        repeat (DEPTH) send_item(8'hF3, 1'b0);
        send_item(8'h66, 1'b0);
        send_item(8'h64, 1'b0);
        send_item(8'h0F, 1'b0);
        repeat (DEPTH) send_item(8'h41, 1'b0);
        send_item(8'hF2, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'h90, 1'b0);
    endtask

    task automatic test_other_modes();
        set_mode(MODE_RSVD);
        send_item(8'h40, 1'b0);
        send_item(8'h66, 1'b0);
        send_item(8'h4F, 1'b0);
        set_mode(MODE_16);
        send_item(8'h67, 1'b0);
        send_item(8'h44, 1'b0);
    endtask

    task automatic test_random();
        logic [1:0] modes [5] = '{MODE_16, MODE_32, MODE_64, MODE_RSVD, MODE_64};
        int stop_at;
        foreach (modes[i]) begin
            set_mode(modes[i]);
            no_idle = (i == 2);
            stop_at = n_sent + 16;
            while (n_sent < stop_at) send_random_instr();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        set_mode(MODE_64);
        @(posedge i_clk);
        hold_req = 80;
        repeat (4) begin
            repeat (4) send_item(random_prefix(), 1'b0);
            send_item(random_terminator(), 1'b0);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_no_prefix();
        test_each_prefix();
        test_rex();
        test_store_full();
        test_other_modes();
        test_random();
        test_backpressure();
        set_mode(MODE_32);
        wait_drained();

        $display("Sent %0d input transactions, checked %0d records over %0d instructions,",
                 n_sent, n_records, n_runs);
        $display("in all four cpu modes, with store overflow and a long output hold-off.");
        if (errors == 0 && record_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d errors, %0d records still expected", errors, record_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
